[rtl/core/bde_pkg.sv]
// Shared types and constants for the button debounce and encoder decode unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package bde_pkg;

  localparam int unsigned TURN_W     = 19;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned NUM_BTN    = 4;
  localparam int unsigned PIN_W      = 6;
  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd50;

  // Word index of the speed factor register.
  localparam logic REG_SPEED = 1'b0;

  // Button indexes inside the pin and event vectors.
  localparam int unsigned BTN_MENU   = 0;
  localparam int unsigned BTN_MANUAL = 1;
  localparam int unsigned BTN_RESET  = 2;
  localparam int unsigned BTN_CLICK  = 3;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2
  } ev_e;

  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_A    = 2'd1,
    PH_B    = 2'd2,
    PH_AB   = 2'd3
  } enc_phase_e;

endpackage

`default_nettype wire

[rtl/core/bde_debounce.sv]
// Four-state, two-sample debouncer for one button, stepped once per tick.
// Depends on bde_pkg for the event codes.
`default_nettype none

module bde_debounce (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            tick_i,
  input  wire            pressed_i,
  output bde_pkg::ev_e   event_o,
  output logic           busy_o
);
  import bde_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_WAIT_DOWN = 4'b0010,
    ST_DOWN      = 4'b0100,
    ST_WAIT_UP   = 4'b1000
  } db_state_e;

  db_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    event_o = EV_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (pressed_i) state_d = ST_WAIT_DOWN;
      end
      ST_WAIT_DOWN: begin
        if (pressed_i) begin
          state_d = ST_DOWN;
          event_o = EV_DOWN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DOWN: begin
        if (!pressed_i) state_d = ST_WAIT_UP;
      end
      ST_WAIT_UP: begin
        state_d = ST_IDLE;
        if (!pressed_i) event_o = EV_UP;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_d != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else if (tick_i) begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bde_encoder.sv]
// Quadrature encoder detent decoder with a saturating signed detent count.
// Depends on bde_pkg for the phase codes.
`default_nettype none

module bde_encoder #(
  parameter int unsigned MAX_DETENTS = 1023,
  parameter int unsigned CNT_W       = 11
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     sample_i,
  input  wire                     enc_a_i,
  input  wire                     enc_b_i,
  input  wire                     clear_i,
  output logic signed [CNT_W-1:0] count_o
);
  import bde_pkg::*;

  localparam logic signed [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DETENTS);
  localparam logic signed [CNT_W-1:0] CNT_MIN = -CNT_MAX;

  enc_phase_e               phase_q, phase_d;
  logic                     armed_q, armed_d;
  logic signed [CNT_W-1:0]  count_q, count_d;

  always_comb begin
    phase_d = phase_q;
    armed_d = armed_q;
    count_d = count_q;
    if (sample_i) begin
      phase_d = enc_phase_e'({enc_b_i, enc_a_i});
      if (phase_d != phase_q) begin
        if (phase_q == PH_AB) begin
          armed_d = 1'b1;
        end else if (phase_q == PH_B && armed_q && phase_d == PH_NONE) begin
          if (count_q < CNT_MAX) count_d = count_q + CNT_W'(1);
          armed_d = 1'b0;
        end else if (phase_q == PH_A && armed_q && phase_d == PH_NONE) begin
          if (count_q > CNT_MIN) count_d = count_q - CNT_W'(1);
          armed_d = 1'b0;
        end
      end
    end else if (clear_i) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_AB;
      armed_q <= 1'b0;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      armed_q <= armed_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= CNT_MAX) && (count_q >= CNT_MIN))
    else $error("Detent count left its saturation range.");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear_i && !sample_i |=> count_q == '0)
    else $error("Detent count not cleared by a tick.");
`endif

endmodule

`default_nettype wire

[rtl/core/button_debounce_and_encoder_decode_unit.sv]
// Top level: input register, encoder decoder, four debouncers, turn scaling
// and result register, plus the speed factor register. Depends on bde_pkg,
// bde_debounce and bde_encoder.
`default_nettype none

// The block takes one transaction per cycle on the slave stream; a stalled
// result holds the input side only once the input register also holds a
// tick. It never needs a clearing pass after reset. An encoder sample
// (tuser = 0) updates the detent decoder and yields no result; a tick
// (tuser = 1) steps the four debouncers and presents one result transaction
// through the input register and then the result register, carrying the
// button events and the detent count since the previous tick, multiplied by
// the speed factor while the manual button is not idle. The single path
// between the two registers holds the 8-bit by count-width multiplier.
module button_debounce_and_encoder_decode_unit #(
  parameter int unsigned MAX_DETENTS = 1023
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Slave stream. tdata from bit 0: enc_a, enc_b, menu_pin, manual_pin,
  // reset_pin, click_pin, two zero bits. tuser: op.
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [7:0]                           s_axis_tdata,
  input  wire                                  s_axis_tuser,
  // Master stream. tdata from bit 0: menu_event[1:0], manual_event[3:2],
  // reset_event[5:4], click_event[7:6], turn_amount[26:8], zeros to bit 31.
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [bde_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // Configuration port.
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [bde_pkg::PADDR_W-1:0]          paddr,
  input  wire  [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import bde_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_DETENTS + 1) + 1;
  localparam int unsigned PROD_W = CNT_W + SPEED_W + 1;
  localparam int unsigned EXT_W  = (PROD_W > TURN_W) ? PROD_W : TURN_W;

  // Configuration register.
  logic [SPEED_W-1:0] speed_q;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_SPEED);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RESET;
    end else if (cfg_we) begin
      speed_q <= pwdata[SPEED_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_SPEED) ? 32'(speed_q) : '0;

  // Input register.
  logic             in_valid_q;
  logic             in_op_q;
  logic [PIN_W-1:0] in_pins_q;
  logic             s_accept;
  logic             advance;
  logic             tick;
  logic             sample;
  logic             out_valid_q;

  assign advance       = in_valid_q && (!in_op_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign tick          = advance && in_op_q;
  assign sample        = advance && !in_op_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= s_axis_tuser;
      in_pins_q <= s_axis_tdata[PIN_W-1:0];
    end
  end

  // Encoder decoder.
  logic signed [CNT_W-1:0] count;

  bde_encoder #(
    .MAX_DETENTS (MAX_DETENTS),
    .CNT_W       (CNT_W)
  ) u_encoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample),
    .enc_a_i  (in_pins_q[0]),
    .enc_b_i  (in_pins_q[1]),
    .clear_i  (tick),
    .count_o  (count)
  );

  // Debouncers.
  ev_e              events [NUM_BTN];
  logic [NUM_BTN-1:0] busy;

  for (genvar gi = 0; gi < NUM_BTN; gi++) begin : g_btn
    bde_debounce u_debounce (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tick_i    (tick),
      .pressed_i (in_pins_q[2 + gi]),
      .event_o   (events[gi]),
      .busy_o    (busy[gi])
    );
  end

  // Turn scaling.
  logic signed [EXT_W-1:0] count_ext;
  logic signed [EXT_W-1:0] speed_ext;
  logic signed [EXT_W-1:0] scaled;
  logic        [TURN_W-1:0] turn;

  assign count_ext = EXT_W'(count);
  assign speed_ext = EXT_W'($signed({1'b0, speed_q}));
  assign scaled    = busy[BTN_MANUAL] ? count_ext * speed_ext : count_ext;
  assign turn      = scaled[TURN_W-1:0];

  // Result register.
  logic [OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      out_data_q <= OUT_DATA_W'({turn, events[BTN_CLICK], events[BTN_RESET],
                                 events[BTN_MANUAL], events[BTN_MENU]});
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef ASSERT_OFF
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> m_axis_tvalid)
    else $error("A tick did not produce a result transaction.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !tick)
    else $error("Result register overwritten while stalled.");

  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && in_op_q && out_valid_q)
    else $error("Input stalled without a pending tick behind a full result.");
`endif

endmodule

`default_nettype wire
